### hw/rtl/cfifo_ow_pkg.sv
// Shared types and constants for the circular FIFO with overwrite.
`default_nettype none

package cfifo_ow_pkg;

  // Default geometry
  localparam int DEPTH_DEF        = 256;
  localparam int ELEMENT_BITS_DEF = 8;

  // Port field widths
  localparam int OP_W     = 3;
  localparam int FIELD_W  = 8;
  localparam int STATUS_W = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_SET_W = 3'd4,
    OP_SET_R = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_DROP   = 2'd2
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/cfifo_ow_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cfifo_ow_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/circular_fifo_with_overwrite_unit.sv
// Circular FIFO with overwrite: top level, operation decode, index state and result stage.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per transfer:
//   push, pop, peek at an offset, skip, set write index or set read index.
//   The result channel (out_valid/out_ready) returns exactly one result per
//   operation: read data, status, fill count, overflow flag and both indexes.
//   cfg_we/cfg_wdata write the overwrite enable; write it only while idle.
//   A result is valid the cycle after its transfer.
//   Throughput is one operation per cycle unless the receiver stalls; the
//   element store is a RAM with one write and one registered read port, and
//   index updates finish in the cycle of the transfer, so back-to-back
//   operations see current state. When the receiver stalls, the result is
//   held and in_ready drops until it is taken; a new operation is accepted
//   in the same cycle the held result transfers.
//   Reset clears both indexes, the overflow flag and the overwrite enable.
//   Store contents are not cleared; set write index can expose unwritten entries.
//   The FIFO keeps one slot free and holds at most DEPTH-1 elements.
`default_nettype none

module circular_fifo_with_overwrite_unit
  import cfifo_ow_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  // operation channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [FIELD_W-1:0]  in_data_in,
  input  wire logic [FIELD_W-1:0]  in_amount,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [FIELD_W-1:0]       out_data_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic [FIELD_W-1:0]       out_fill_count,
  output logic                     out_overflowed,
  output logic [FIELD_W-1:0]       out_write_index,
  output logic [FIELD_W-1:0]       out_read_index
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int AW     = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;
  localparam int DW     = (ELEMENT_BITS > FIELD_W) ? ELEMENT_BITS : FIELD_W;
  localparam int AMT_N  = 1 << FIELD_W;
  localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);
  localparam logic [AW-1:0] CAP_A   = AW'(DEPTH - 1);

  // Modular helpers; operands are below DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW-1:0] s;
    s = a + b;
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s;
  endfunction

  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW-1:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + DEPTH_A - b;
    end
    return d;
  endfunction

  // State
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             flag_r, flag_nxt;
  logic             ovw_r;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic             rd_sel_r, rd_sel_nxt;

  // Decode and datapath signals
  logic             in_fire;
  op_t              op;
  logic [AW-1:0]    head_a, tail_a, amt_a, count_a;
  logic [AW-1:0]    head_inc, set_idx_a, len_a;
  logic [IDX_W-1:0] mod_tbl [AMT_N];
  logic [IDX_W-1:0] set_idx;
  logic             ram_we_c, ram_re_c;
  logic [IDX_W-1:0] ram_raddr;
  logic [DW-1:0]    din_ext, rd_ext;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  // amount mod DEPTH, precomputed constant table
  for (genvar g = 0; g < AMT_N; g++) begin : g_mod
    assign mod_tbl[g] = IDX_W'(g % DEPTH);
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(in_op);

  assign head_a    = AW'(head_r);
  assign tail_a    = AW'(tail_r);
  assign amt_a     = AW'(in_amount);
  assign count_a   = wrap_sub(head_a, tail_a);
  assign head_inc  = wrap_add(head_a, AW'(1));
  assign set_idx   = mod_tbl[in_amount];
  assign set_idx_a = AW'(set_idx);
  assign din_ext   = DW'(in_data_in);

  // Operation decode
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    flag_nxt   = flag_r;
    status_nxt = ST_DONE;
    rd_sel_nxt = 1'b0;
    ram_we_c   = 1'b0;
    ram_re_c   = 1'b0;
    ram_raddr  = tail_r;
    len_a      = '0;
    unique case (op)
      OP_PUSH: begin
        if (count_a < CAP_A) begin
          ram_we_c = 1'b1;
          head_nxt = head_inc[IDX_W-1:0];
        end else if (ovw_r) begin
          // full: drop the oldest element
          ram_we_c = 1'b1;
          head_nxt = head_inc[IDX_W-1:0];
          tail_nxt = IDX_W'(wrap_add(head_inc, AW'(1)));
          flag_nxt = 1'b1;
        end else begin
          status_nxt = ST_DROP;
        end
      end
      OP_POP: begin
        if (count_a == '0) begin
          status_nxt = ST_REJECT;
        end else begin
          ram_re_c   = 1'b1;
          rd_sel_nxt = 1'b1;
          tail_nxt   = IDX_W'(wrap_add(tail_a, AW'(1)));
        end
        flag_nxt = 1'b0;
      end
      OP_PEEK: begin
        if (amt_a >= count_a) begin
          status_nxt = ST_REJECT;
        end else begin
          ram_re_c   = 1'b1;
          rd_sel_nxt = 1'b1;
          ram_raddr  = IDX_W'(wrap_add(tail_a, amt_a));
        end
      end
      OP_SKIP: begin
        if (amt_a > count_a) begin
          status_nxt = ST_REJECT;
        end else begin
          tail_nxt = IDX_W'(wrap_add(tail_a, amt_a));
        end
      end
      OP_SET_W: begin
        // outside writer moved past free space: oldest data lost
        len_a = wrap_sub(set_idx_a, head_a);
        if ((CAP_A - count_a) < len_a) begin
          flag_nxt = 1'b1;
          tail_nxt = IDX_W'(wrap_add(set_idx_a, AW'(1)));
        end
        head_nxt = set_idx;
      end
      OP_SET_R: begin
        len_a = wrap_sub(set_idx_a, tail_a);
        if (count_a < len_a) begin
          status_nxt = ST_REJECT;
        end else begin
          tail_nxt = set_idx;
        end
      end
      default: begin
        status_nxt = ST_REJECT;
      end
    endcase
  end

  // Element store
  cfifo_ow_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && ram_we_c),
    .waddr (head_r),
    .wdata (din_ext[ELEMENT_BITS-1:0]),
    .re    (in_fire && ram_re_c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovw_r <= 1'b0;
    end else if (cfg_we) begin
      ovw_r <= cfg_wdata;
    end
  end

  // Index state and flag, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      flag_r <= 1'b0;
    end else if (in_fire) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      flag_r <= flag_nxt;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
      if (in_valid) begin
        rd_sel_r <= rd_sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
    end
  end

  // State registers only change on a transfer, which retires the held
  // result, so they always match the result on the port.
  assign rd_ext          = DW'(ram_rdata);
  assign out_valid       = out_valid_r;
  assign out_data_out    = rd_sel_r ? rd_ext[FIELD_W-1:0] : '0;
  assign out_status      = status_r;
  assign out_fill_count  = count_a[FIELD_W-1:0];
  assign out_overflowed  = flag_r;
  assign out_write_index = head_a[FIELD_W-1:0];
  assign out_read_index  = tail_a[FIELD_W-1:0];

endmodule

`default_nettype wire
